>>> rtl/core/dfuf_pkg.sv
package dfuf_pkg;

    // Forest size and widths
    localparam int NODES   = 1024;
    localparam int IDX_W   = $clog2(NODES);
    localparam int NODE_W  = 10;
    localparam int FUNC_W  = 2;
    localparam int FIND_W  = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_FIRST  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SECOND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_JOINT  = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_WALK,
        ST_COMP_START,
        ST_COMP,
        ST_LINK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr_wr;      // clearing pass write and count
        logic load_in;     // capture accepted item
        logic find_start;  // read start node of current find
        logic walk_step;   // follow parent pointer
        logic root_hit;    // capture root of current find
        logic comp_start;  // re-read start node for compression
        logic comp_step;   // point node at root, move on
        logic find_next;   // advance to next find
        logic link;        // place first root under second
        logic out_load;    // load result register
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic op_ok;
        logic walk_hit;
        logic comp_hit;
        logic last_find;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/core/dfuf_ctrl.sv
module dfuf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dfuf_pkg::stat_t stat,
    output dfuf_pkg::cmd_t  cmd
);
    import dfuf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_FIND;
                end
            end
            ST_FIND: begin
                if (!stat.op_ok) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.find_start = 1'b1;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK: begin
                if (stat.walk_hit) begin
                    cmd.root_hit = 1'b1;
                    state_next   = ST_COMP_START;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_COMP_START: begin
                cmd.comp_start = 1'b1;
                state_next     = ST_COMP;
            end
            ST_COMP: begin
                if (!stat.comp_hit) begin
                    cmd.comp_step = 1'b1;
                end else if (stat.last_find) begin
                    state_next = ST_LINK;
                end else begin
                    cmd.find_next = 1'b1;
                    state_next    = ST_FIND;
                end
            end
            ST_LINK: begin
                cmd.link   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/core/dfuf_datapath.sv
module dfuf_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [dfuf_pkg::FUNC_W-1:0]   s_func,
    input  logic [dfuf_pkg::NODE_W-1:0]   s_node_a,
    input  logic [dfuf_pkg::NODE_W-1:0]   s_node_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_merged,
    input  dfuf_pkg::cmd_t                cmd,
    output dfuf_pkg::stat_t               stat
);
    import dfuf_pkg::*;

    // Parent tables
    idx_t mem0 [NODES];
    idx_t mem1 [NODES];

    logic [FUNC_W-1:0] func_reg;
    idx_t              a_reg;
    idx_t              b_reg;
    logic              ok_reg;
    logic [FIND_W-1:0] fidx_reg;
    idx_t              cur_reg;
    idx_t              cur_next;
    idx_t              root_reg;
    idx_t              roots_reg [4];
    idx_t              clr_idx_reg;
    idx_t              rd0_reg;
    idx_t              rd1_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              m_merged_reg;

    logic forest;
    idx_t start;
    idx_t rdata;
    idx_t raddr;
    logic merged;
    logic in_ok;
    logic we0, we1;
    idx_t wa0, wa1, wd0, wd1;

    // Finds run a, b in the first forest then a, b in the second for a joint union
    assign forest = (func_reg == FUNC_JOINT) ? fidx_reg[1] : func_reg[0];
    assign start  = fidx_reg[0] ? b_reg : a_reg;
    assign rdata  = forest ? rd1_reg : rd0_reg;
    assign raddr  = (cmd.find_start || cmd.comp_start) ? start : rdata;

    assign in_ok = (32'(s_node_a) < NODES) && (32'(s_node_b) < NODES)
                && (s_func == FUNC_FIRST || s_func == FUNC_SECOND || s_func == FUNC_JOINT);

    assign merged = (func_reg == FUNC_JOINT)
                  ? ((roots_reg[0] != roots_reg[1]) && (roots_reg[2] != roots_reg[3]))
                  : (roots_reg[0] != roots_reg[1]);

    always_comb begin
        if (cmd.find_start || cmd.comp_start) begin
            cur_next = start;
        end else if (cmd.walk_step || cmd.comp_step) begin
            cur_next = rdata;
        end else begin
            cur_next = cur_reg;
        end
    end

    // Write ports: clearing, compression or link
    always_comb begin
        we0 = 1'b0;
        wa0 = clr_idx_reg;
        wd0 = clr_idx_reg;
        we1 = 1'b0;
        wa1 = clr_idx_reg;
        wd1 = clr_idx_reg;
        if (cmd.clr_wr) begin
            we0 = 1'b1;
            we1 = 1'b1;
        end else if (cmd.comp_step) begin
            we0 = !forest;
            we1 = forest;
            wa0 = cur_reg;
            wd0 = root_reg;
            wa1 = cur_reg;
            wd1 = root_reg;
        end else if (cmd.link && merged) begin
            we0 = (func_reg == FUNC_FIRST) || (func_reg == FUNC_JOINT);
            wa0 = roots_reg[0];
            wd0 = roots_reg[1];
            we1 = (func_reg == FUNC_SECOND) || (func_reg == FUNC_JOINT);
            wa1 = (func_reg == FUNC_JOINT) ? roots_reg[2] : roots_reg[0];
            wd1 = (func_reg == FUNC_JOINT) ? roots_reg[3] : roots_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (we0) begin
            mem0[wa0] <= wd0;
        end
        rd0_reg <= mem0[raddr];
    end

    always_ff @(posedge aclk) begin
        if (we1) begin
            mem1[wa1] <= wd1;
        end
        rd1_reg <= mem1[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg <= s_func;
            a_reg    <= IDX_W'(s_node_a);
            b_reg    <= IDX_W'(s_node_b);
            ok_reg   <= in_ok;
        end
        cur_reg <= cur_next;
        if (cmd.root_hit) begin
            root_reg            <= cur_reg;
            roots_reg[fidx_reg] <= cur_reg;
        end
        if (cmd.out_load) begin
            m_merged_reg <= ok_reg && merged;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            fidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.clr_wr) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.load_in) begin
                fidx_reg <= '0;
            end else if (cmd.find_next) begin
                fidx_reg <= fidx_reg + 1'b1;
            end
        end
    end

    assign stat.clr_last  = (clr_idx_reg == IDX_W'(NODES - 1));
    assign stat.op_ok     = ok_reg;
    assign stat.walk_hit  = (rdata == cur_reg);
    assign stat.comp_hit  = (rdata == root_reg);
    assign stat.last_find = (func_reg == FUNC_JOINT) ? (fidx_reg == 2'd3) : (fidx_reg == 2'd1);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_merged = m_merged_reg;

endmodule

>>> rtl/core/dual_forest_union_find_unit.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_func[1:0], s_node_a[9:0], s_node_b[9:0]
// m_        out        m_valid / m_ready   m_merged
//
// Reset: a clearing pass writes every entry of both parent tables with its own
//   index; s_ready stays low until it ends.
// Per item: two finds for a single-forest union, four for a joint union, each
//   walking to the root and then compressing the path. The walks follow the
//   parent table, one pointer per cycle through the registered read port.
// An item with an unused operation or a node out of range goes straight to the done state.
// A stalled m_ready holds the result register; the next item is taken meanwhile
//   and its result waits in the done state until the register frees.
module dual_forest_union_find_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dfuf_pkg::FUNC_W-1:0]   s_func,
    input  logic [dfuf_pkg::NODE_W-1:0]   s_node_a,
    input  logic [dfuf_pkg::NODE_W-1:0]   s_node_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_merged
);
    import dfuf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer: clearing pass, find walks, compression, link, result hand-off
    dfuf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Parent tables, walk registers, found roots and the result register
    dfuf_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_func   (s_func),
        .s_node_a (s_node_a),
        .s_node_b (s_node_b),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_merged (m_merged),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Result only loaded into a free output register
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result loaded over a pending item");

    // One item in flight: no acceptance straight after an acceptance
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while busy");

    // Clearing, compression and link never share the write ports
    a_wr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.comp_step && cmd.link) && !(cmd.clr_wr && (cmd.comp_step || cmd.link)))
        else $error("parent table write conflict");

    // A completed result comes from a fresh load
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("result valid without a load");

endmodule
